// File: rtl/slsb_pkg.sv
// Shared types, widths and codes for the sRGB linear-light solid blend block.
`timescale 1ns / 1ps

package slsb_pkg;

    // Port and field widths.
    localparam int OPCODE_W    = 2;
    localparam int PIXEL_W     = 32;
    localparam int INDEX_W     = 12;
    localparam int VALUE_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Datapath widths.
    localparam int NUM_CH   = 3;
    localparam int CH_W     = 8;
    localparam int LIN_W    = 16;
    localparam int SCALED_W = 24;
    localparam int PROD_W   = 24;
    localparam int SUM_W    = 25;
    localparam int QUOT_W   = 18;
    localparam int RECIP_W  = 26;
    localparam int QPROD_W  = SUM_W + RECIP_W;

    // Table geometry.
    localparam int DEC_DEPTH = 256;
    localparam int DEC_AW    = 8;
    localparam int ENC_DEPTH = 4096;
    localparam int ENC_AW    = 12;

    // Queue geometry.
    localparam int MIDQ_DEPTH = 4;
    localparam int MIDQ_AW    = 2;
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = 3;

    // Default encode index shift.
    localparam int ENCODE_INDEX_SHIFT_DEF = 4;

    // Exact division by 255 for sums below 2^25: multiply by ceil(2^33/255), keep bits 33 up.
    localparam logic [RECIP_W-1:0] DIV255_RECIP = 26'd33686019;
    localparam int                 DIV255_SHIFT = 33;
    localparam logic [CH_W-1:0]    ROUND_BIAS   = 8'd127;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OPC_BLEND     = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_DEC_WRITE = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_ENC_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ALPHA  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_ALPHA = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_SCALED    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_SCALED  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_SCALED   = 3'd4;

    // Work class of an item once the front has decoded it.
    typedef enum logic [1:0] {
        OP_BLEND,
        OP_DEC_WRITE,
        OP_ENC_WRITE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [PIXEL_W-1:0] pixel;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]     source_alpha;
        logic [CH_W-1:0]     inverse_alpha;
        logic [SCALED_W-1:0] red_scaled;
        logic [SCALED_W-1:0] green_scaled;
        logic [SCALED_W-1:0] blue_scaled;
    } cfg_t;

endpackage

// File: rtl/slsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module slsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/slsb_front.sv
// Front end: accepts input beats, classifies them and queues work for the back end.
`timescale 1ns / 1ps

module slsb_front import slsb_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [PIXEL_W-1:0]  dest_pixel,
    input  logic [INDEX_W-1:0]  table_index,
    input  logic [VALUE_W-1:0]  table_value,
    output item_t               item,
    output logic                item_valid,
    input  logic                item_pop
);

    item_t              mem_reg [MIDQ_DEPTH];
    logic [MIDQ_AW-1:0] wr_ptr_reg;
    logic [MIDQ_AW-1:0] rd_ptr_reg;
    logic [MIDQ_AW:0]   count_reg;
    logic [MIDQ_AW:0]   count_next;

    logic  accept;
    logic  keep;
    op_t   op;
    item_t new_item;

    assign full   = (count_reg == (MIDQ_AW + 1)'(MIDQ_DEPTH));
    assign accept = push && !full;

    // Unused opcodes are taken and dropped here.
    always_comb
    begin
        keep = 1'b0;
        op   = OP_BLEND;
        case (opcode)
            OPC_BLEND:
            begin
                keep = accept;
                op   = OP_BLEND;
            end
            OPC_DEC_WRITE:
            begin
                keep = accept;
                op   = OP_DEC_WRITE;
            end
            OPC_ENC_WRITE:
            begin
                keep = accept;
                op   = OP_ENC_WRITE;
            end
            default:
            begin
                keep = 1'b0;
                op   = OP_BLEND;
            end
        endcase
    end

    always_comb
    begin
        new_item.op    = op;
        new_item.pixel = dest_pixel;
        new_item.index = table_index;
        new_item.value = table_value;
    end

    assign count_next = count_reg + {{MIDQ_AW{1'b0}}, keep} - {{MIDQ_AW{1'b0}}, item_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (keep)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign item       = mem_reg[rd_ptr_reg];
    assign item_valid = (count_reg != '0);

endmodule

// File: rtl/slsb_back.sv
// Back end: table writes and the five-stage linear-light blend pipeline.
`timescale 1ns / 1ps

module slsb_back import slsb_pkg::*; #(
    parameter int ENCODE_INDEX_SHIFT = ENCODE_INDEX_SHIFT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  item_t              item,
    input  logic               item_valid,
    output logic               item_pop,
    input  logic [OUTQ_AW:0]   out_count,
    output logic               result_push,
    output logic [PIXEL_W-1:0] result_pixel
);

    localparam int INFL_W = 3;
    localparam int RES_W  = OUTQ_AW + 2;

    // Stage valid and class.
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, p5_blend_reg;
    op_t  p1_op_reg, p2_op_reg, p3_op_reg, p4_op_reg;

    // Encode-table writes ride along so they land in order with blend reads.
    logic [ENC_AW-1:0] p1_enc_addr_reg, p2_enc_addr_reg, p3_enc_addr_reg, p4_enc_addr_reg;
    logic [CH_W-1:0]   p1_enc_data_reg, p2_enc_data_reg, p3_enc_data_reg, p4_enc_data_reg;

    // Alpha path.
    logic [CH_W-1:0]  p1_da_reg;
    logic [LIN_W-1:0] p2_ax_reg;
    logic [CH_W-1:0]  p3_alpha_reg, p4_alpha_reg, p5_alpha_reg;

    // Color path.
    logic [NUM_CH-1:0][PROD_W-1:0] p2_prod_reg;
    logic [NUM_CH-1:0][SUM_W-1:0]  p3_sum_reg;
    logic [NUM_CH-1:0][QUOT_W-1:0] p4_quot_reg;

    logic [NUM_CH-1:0][LIN_W-1:0]    lin;
    logic [NUM_CH-1:0][SCALED_W-1:0] scaled;
    logic [NUM_CH-1:0][PROD_W-1:0]   p2_prod_next;
    logic [NUM_CH-1:0][SUM_W-1:0]    p3_sum_next;
    logic [NUM_CH-1:0][QUOT_W-1:0]   p4_quot_next;
    logic [NUM_CH-1:0][ENC_AW-1:0]   enc_raddr;
    logic [NUM_CH-1:0][CH_W-1:0]     enc_rdata;
    logic [NUM_CH-1:0][QPROD_W-1:0]  qprod;
    logic [NUM_CH-1:0][LIN_W-1:0]    q16;

    logic [LIN_W-1:0] p2_ax_next;
    logic [16:0]      alpha_round;
    logic [CH_W:0]    alpha_sum;
    logic [CH_W-1:0]  p3_alpha_next;

    logic              dec_we;
    logic              enc_we;
    logic [INFL_W-1:0] inflight;
    logic [RES_W-1:0]  reserved;
    logic              p1_blend, p2_blend, p3_blend, p4_blend;

    assign scaled = {cfg.blue_scaled, cfg.green_scaled, cfg.red_scaled};

    assign p1_blend = p1_valid_reg && (p1_op_reg == OP_BLEND);
    assign p2_blend = p2_valid_reg && (p2_op_reg == OP_BLEND);
    assign p3_blend = p3_valid_reg && (p3_op_reg == OP_BLEND);
    assign p4_blend = p4_valid_reg && (p4_op_reg == OP_BLEND);

    // A blend is started only when its result has a guaranteed slot in the output queue.
    assign inflight = {2'b00, p1_blend} + {2'b00, p2_blend} + {2'b00, p3_blend}
                    + {2'b00, p4_blend} + {2'b00, p5_blend_reg};
    assign reserved = RES_W'(out_count) + RES_W'(inflight);
    assign item_pop = item_valid
                   && ((item.op != OP_BLEND) || (reserved < RES_W'(OUTQ_DEPTH)));

    assign dec_we = item_pop && (item.op == OP_DEC_WRITE);
    assign enc_we = p4_valid_reg && (p4_op_reg == OP_ENC_WRITE);

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_ch
        slsb_ram #(
            .WIDTH (LIN_W),
            .DEPTH (DEC_DEPTH)
        ) u_dec_ram (
            .clk   (clk),
            .we    (dec_we),
            .waddr (item.index[DEC_AW-1:0]),
            .wdata (item.value),
            .raddr (item.pixel[c*CH_W +: CH_W]),
            .rdata (lin[c])
        );

        slsb_ram #(
            .WIDTH (CH_W),
            .DEPTH (ENC_DEPTH)
        ) u_enc_ram (
            .clk   (clk),
            .we    (enc_we),
            .waddr (p4_enc_addr_reg),
            .wdata (p4_enc_data_reg),
            .raddr (enc_raddr[c]),
            .rdata (enc_rdata[c])
        );
    end

    // Per-channel arithmetic, one operation class per stage.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            p2_prod_next[c] = PROD_W'(lin[c]) * PROD_W'(cfg.inverse_alpha);
            p3_sum_next[c]  = SUM_W'(p2_prod_reg[c]) + SUM_W'(scaled[c]) + SUM_W'(ROUND_BIAS);
            qprod[c]        = QPROD_W'(p3_sum_reg[c]) * QPROD_W'(DIV255_RECIP);
            p4_quot_next[c] = qprod[c][DIV255_SHIFT +: QUOT_W];
            q16[c]          = (|p4_quot_reg[c][QUOT_W-1:LIN_W]) ? {LIN_W{1'b1}}
                                                                 : p4_quot_reg[c][LIN_W-1:0];
            enc_raddr[c]    = ENC_AW'(q16[c] >> ENCODE_INDEX_SHIFT);
        end
    end

    // Alpha: x/255 for x below 65535 is (x + (x >> 8) + 1) >> 8.
    always_comb
    begin
        p2_ax_next    = LIN_W'(p1_da_reg) * LIN_W'(cfg.inverse_alpha) + LIN_W'(ROUND_BIAS);
        alpha_round   = 17'(p2_ax_reg) + 17'(p2_ax_reg >> 8) + 17'd1;
        alpha_sum     = {1'b0, cfg.source_alpha} + {1'b0, alpha_round[15:8]};
        p3_alpha_next = alpha_sum[CH_W] ? {CH_W{1'b1}} : alpha_sum[CH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_blend_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= item_pop;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_blend_reg <= p4_blend;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_op_reg       <= item.op;
        p1_da_reg       <= item.pixel[PIXEL_W-1 -: CH_W];
        p1_enc_addr_reg <= item.index[ENC_AW-1:0];
        p1_enc_data_reg <= item.value[CH_W-1:0];

        p2_op_reg       <= p1_op_reg;
        p2_ax_reg       <= p2_ax_next;
        p2_prod_reg     <= p2_prod_next;
        p2_enc_addr_reg <= p1_enc_addr_reg;
        p2_enc_data_reg <= p1_enc_data_reg;

        p3_op_reg       <= p2_op_reg;
        p3_alpha_reg    <= p3_alpha_next;
        p3_sum_reg      <= p3_sum_next;
        p3_enc_addr_reg <= p2_enc_addr_reg;
        p3_enc_data_reg <= p2_enc_data_reg;

        p4_op_reg       <= p3_op_reg;
        p4_alpha_reg    <= p3_alpha_reg;
        p4_quot_reg     <= p4_quot_next;
        p4_enc_addr_reg <= p3_enc_addr_reg;
        p4_enc_data_reg <= p3_enc_data_reg;

        p5_alpha_reg    <= p4_alpha_reg;
    end

    assign result_push  = p5_blend_reg;
    assign result_pixel = {p5_alpha_reg, enc_rdata[2], enc_rdata[1], enc_rdata[0]};

`ifndef SYNTHESIS
    a_no_outq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        result_push |-> (out_count < (OUTQ_AW + 1)'(OUTQ_DEPTH)))
        else $error("result pushed into a full output queue");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserved <= RES_W'(OUTQ_DEPTH))
        else $error("output queue credit exceeded");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid)
        else $error("work queue popped while empty");

    a_blend_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (item_pop && (item.op == OP_BLEND)) |-> ##5 result_push)
        else $error("blend beat did not emerge after five cycles");
`endif

endmodule

// File: rtl/slsb_outq.sv
// Output queue that holds finished pixels until the receiver pops them.
`timescale 1ns / 1ps

module slsb_outq import slsb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [PIXEL_W-1:0] push_data,
    input  logic               pop,
    output logic               empty,
    output logic [PIXEL_W-1:0] data,
    output logic [OUTQ_AW:0]   count
);

    logic [PIXEL_W-1:0] mem_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg;
    logic [OUTQ_AW-1:0] rd_ptr_reg;
    logic [OUTQ_AW:0]   count_reg;
    logic [OUTQ_AW:0]   count_next;
    logic               take;

    assign empty      = (count_reg == '0);
    assign take       = pop && !empty;
    assign count_next = count_reg + {{OUTQ_AW{1'b0}}, push} - {{OUTQ_AW{1'b0}}, take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign data  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: rtl/srgb_linear_solid_blend.sv
// Top level of the sRGB solid-color blend block done in linear light.
`timescale 1ns / 1ps

// Usage overview.
// The input side behaves like a queue: a beat is taken at a rising edge where push is high
// and full is low. Opcode 0 blends dest_pixel with the configured solid color, opcode 1
// writes the 256-entry decode table (sRGB byte to 16-bit linear), opcode 2 writes the
// 4096-entry encode table, and opcode 3 is taken and dropped. Only blend beats make a result.
// The result side also behaves like a queue: while empty is low the oldest blended pixel is
// on blended_pixel, and a beat leaves at a rising edge where pop is high.
// The configuration port writes source_alpha, inverse_alpha and the three premultiplied
// scaled terms at any edge with cfg_write high; write them only while the block is idle.
// A blend beat passes the work queue and then five pipeline stages (decode RAM, multiply,
// add, reciprocal divide by 255, and encode RAM) before it shows on the result side.
// One beat per cycle is sustained; the 8-deep output queue sets how many blends may be
// outstanding, so the front stalls only when the receiver stops popping.
// Reset clears the queues and restores register defaults (inverse_alpha 255, others 0).
// Table contents are undefined after reset; load every entry a pixel can reach before use.
// When pop stays low, results collect in the output queue, then the work queue fills and
// full rises; nothing is dropped.

module srgb_linear_solid_blend import slsb_pkg::*; #(
    parameter int ENCODE_INDEX_SHIFT = ENCODE_INDEX_SHIFT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [PIXEL_W-1:0]     dest_pixel,
    input  logic [INDEX_W-1:0]     table_index,
    input  logic [VALUE_W-1:0]     table_value,
    output logic                   empty,
    input  logic                   pop,
    output logic [PIXEL_W-1:0]     blended_pixel
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    item_t              item;
    logic               item_valid;
    logic               item_pop;
    logic [OUTQ_AW:0]   out_count;
    logic               result_push;
    logic [PIXEL_W-1:0] result_pixel;

    // Configuration registers; writes to unused indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_ALPHA:  cfg_next.source_alpha  = cfg_data[CH_W-1:0];
                REG_INVERSE_ALPHA: cfg_next.inverse_alpha = cfg_data[CH_W-1:0];
                REG_RED_SCALED:    cfg_next.red_scaled    = cfg_data[SCALED_W-1:0];
                REG_GREEN_SCALED:  cfg_next.green_scaled  = cfg_data[SCALED_W-1:0];
                REG_BLUE_SCALED:   cfg_next.blue_scaled   = cfg_data[SCALED_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_alpha  <= '0;
            cfg_reg.inverse_alpha <= {CH_W{1'b1}};
            cfg_reg.red_scaled    <= '0;
            cfg_reg.green_scaled  <= '0;
            cfg_reg.blue_scaled   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accept and classify beats into a short work queue.
    slsb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .dest_pixel  (dest_pixel),
        .table_index (table_index),
        .table_value (table_value),
        .item        (item),
        .item_valid  (item_valid),
        .item_pop    (item_pop)
    );

    // Back end: table writes and the blend pipeline, gated by output queue credit.
    slsb_back #(
        .ENCODE_INDEX_SHIFT (ENCODE_INDEX_SHIFT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .out_count    (out_count),
        .result_push  (result_push),
        .result_pixel (result_pixel)
    );

    // Result queue toward the receiver.
    slsb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_push),
        .push_data (result_pixel),
        .pop       (pop),
        .empty     (empty),
        .data      (blended_pixel),
        .count     (out_count)
    );

endmodule

// File: tb/srgb_linear_solid_blend_tb.sv
// Self-checking testbench for the linear-light solid-color blend block.
`timescale 1ns / 1ps

// The testbench keeps its own copy of both lookup tables and the five settings
// registers. Each beat the block takes is applied to that copy in the same order,
// and each blend beat leaves one predicted pixel in a queue. A separate receiver
// process pops results and compares them against the head of that queue.
//
// Table entries come up undefined after reset, so a blend is only offered once every
// entry it can touch holds a known value. Before each blend, the sender loads any
// missing decode entries for the three color bytes. It then works out the encode
// slots the pixel will reach and loads any of those that are missing.

module srgb_linear_solid_blend_tb;
    import slsb_pkg::*;

    localparam int ENC_SHIFT = ENCODE_INDEX_SHIFT_DEF;

    // Opcode 3 has no meaning; the block takes the beat and drops it.
    localparam logic [OPCODE_W-1:0] OPC_UNUSED = 2'd3;

    // Arithmetic constants of the blend.
    localparam logic [31:0]         ROUND_TERM = 32'd127;
    localparam logic [31:0]         DIV_BY     = 32'd255;
    localparam logic [31:0]         LIN_MAX    = 32'd65535;
    localparam logic [31:0]         ALPHA_MAX  = 32'd255;
    localparam logic [SCALED_W-1:0] SCALED_TOP = 24'd16711425;

    // Margin for load beats that are still in the pipeline
    // when the last pixel has come out.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 230;
    localparam int RANDOM_PHASES = 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [OPCODE_W-1:0]    opcode = OPC_BLEND;
    logic [PIXEL_W-1:0]     dest_pixel = '0;
    logic [INDEX_W-1:0]     table_index = '0;
    logic [VALUE_W-1:0]     table_value = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [PIXEL_W-1:0]     blended_pixel;

    // Mirror of the block's tables, with a flag per entry that records whether it
    // has been written.
    logic [LIN_W-1:0] dec_lut [DEC_DEPTH];
    bit               dec_loaded [DEC_DEPTH];
    logic [CH_W-1:0]  enc_lut [ENC_DEPTH];
    bit               enc_loaded [ENC_DEPTH];

    // Mirror of the settings registers, starting from their reset values.
    logic [CH_W-1:0]     cur_src_alpha = 8'd0;
    logic [CH_W-1:0]     cur_inv_alpha = 8'd255;
    logic [SCALED_W-1:0] cur_scaled [NUM_CH] = '{24'd0, 24'd0, 24'd0};

    logic [PIXEL_W-1:0] pending_pixels [$];
    logic [PIXEL_W-1:0] want_pixel;
    int unsigned        fault_count = 0;

    // Number of input beats the block has taken so far, of every kind.
    int unsigned        beat_count = 0;

    // These control how the sender and the receiver pace their beats.
    bit          tx_steady = 1'b0;
    int unsigned tx_burst_left = 0;
    bit          rx_steady = 1'b0;
    bit          rx_popping = 1'b0;
    int unsigned rx_phase_left = 0;
    int unsigned rx_hold_left = 0;

    srgb_linear_solid_blend #(
        .ENCODE_INDEX_SHIFT(ENC_SHIFT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .dest_pixel   (dest_pixel),
        .table_index  (table_index),
        .table_value  (table_value),
        .empty        (empty),
        .pop          (pop),
        .blended_pixel(blended_pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Encode slot that one color channel reaches: the decoded value is weighted by
    // the inverse alpha, the scaled source term and the rounding bias are added, and
    // the sum is divided by 255. The quotient is clamped to 16 bits and shifted down
    // to form the table index.
    function automatic logic [ENC_AW-1:0] encode_slot(input logic [CH_W-1:0] srgb,
                                                       input logic [SCALED_W-1:0] scaled);
        logic [31:0] lin;
        logic [31:0] weight;
        logic [31:0] acc;
        logic [31:0] quot;
        lin = 32'(dec_lut[srgb]);
        weight = 32'(cur_inv_alpha);
        acc = lin * weight + 32'(scaled) + ROUND_TERM;
        quot = acc / DIV_BY;
        if (quot > LIN_MAX)
            quot = LIN_MAX;
        quot = quot >> ENC_SHIFT;
        return quot[ENC_AW-1:0];
    endfunction

    // Pixel expected from a blend beat, computed under the current table and
    // register mirrors.
    function automatic logic [PIXEL_W-1:0] expected_blend(input logic [PIXEL_W-1:0] pix);
        logic [PIXEL_W-1:0] result;
        logic [31:0]        dest_alpha;
        logic [31:0]        weight;
        logic [31:0]        alpha_sum;
        int                 ch;
        for (ch = 0; ch < NUM_CH; ch++)
            result[8*ch +: 8] = enc_lut[encode_slot(pix[8*ch +: 8], cur_scaled[ch])];
        dest_alpha = 32'(pix[31:24]);
        weight = 32'(cur_inv_alpha);
        alpha_sum = 32'(cur_src_alpha) + (dest_alpha * weight + ROUND_TERM) / DIV_BY;
        if (alpha_sum > ALPHA_MAX)
            alpha_sum = ALPHA_MAX;
        result[31:24] = alpha_sum[7:0];
        return result;
    endfunction

    task automatic log_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    // Offers one beat and holds it until the block takes it. The mirrors are updated
    // at the edge that takes the beat. After that, the sender may take a random gap
    // when its current burst is used up.
    task automatic offer_beat(input logic [OPCODE_W-1:0] op, input logic [PIXEL_W-1:0] pix,
                              input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        push <= 1'b1;
        opcode <= op;
        dest_pixel <= pix;
        table_index <= idx;
        table_value <= val;
        do
            @(posedge clk);
        while (full !== 1'b0);
        beat_count++;
        case (op)
            OPC_DEC_WRITE:
            begin
                dec_lut[idx[DEC_AW-1:0]] = val;
                dec_loaded[idx[DEC_AW-1:0]] = 1'b1;
            end
            OPC_ENC_WRITE:
            begin
                enc_lut[idx] = val[CH_W-1:0];
                enc_loaded[idx] = 1'b1;
            end
            OPC_BLEND:
                pending_pixels.push_back(expected_blend(pix));
            default:
                ;
        endcase
        if (!tx_steady)
        begin
            if (tx_burst_left == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                tx_burst_left = $urandom_range(1, 30);
            end
            else
                tx_burst_left--;
        end
    endtask

    // Loads every table entry that this pixel can reach and that is still
    // unwritten, then offers the blend beat itself. The index and value fields of
    // the blend beat carry random data, which the block must ignore.
    task automatic blend_with_tables(input logic [PIXEL_W-1:0] pix);
        logic [31:0]       noise;
        logic [31:0]       fill;
        logic [ENC_AW-1:0] slot;
        int                ch;
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            noise = $urandom;
            fill = $urandom;
            if (!dec_loaded[pix[8*ch +: 8]])
                offer_beat(OPC_DEC_WRITE, fill, {noise[3:0], pix[8*ch +: 8]}, noise[31:16]);
        end
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            noise = $urandom;
            fill = $urandom;
            slot = encode_slot(pix[8*ch +: 8], cur_scaled[ch]);
            if (!enc_loaded[slot])
                offer_beat(OPC_ENC_WRITE, fill, slot, noise[15:0]);
        end
        noise = $urandom;
        offer_beat(OPC_BLEND, pix, noise[11:0], noise[31:16]);
    endtask

    // Stops offering beats and waits until every expected pixel has come back. It
    // then waits for load beats, which produce no result, to leave the pipeline.
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        push <= 1'b0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers back to back; only called while the block is idle.
    // The 8-bit registers get random upper data bits, which the block must drop.
    task automatic apply_settings(input logic [CH_W-1:0] src_alpha,
                                  input logic [CH_W-1:0] inv_alpha,
                                  input logic [SCALED_W-1:0] red,
                                  input logic [SCALED_W-1:0] green,
                                  input logic [SCALED_W-1:0] blue);
        logic [CFG_DATA_W-1:0]  word [5];
        logic [CFG_INDEX_W-1:0] slot [5];
        logic [31:0]            junk;
        int                     k;
        junk = $urandom;
        word[0] = {junk[15:0], src_alpha};
        word[1] = {junk[31:16], inv_alpha};
        word[2] = red;
        word[3] = green;
        word[4] = blue;
        slot[0] = REG_SOURCE_ALPHA;
        slot[1] = REG_INVERSE_ALPHA;
        slot[2] = REG_RED_SCALED;
        slot[3] = REG_GREEN_SCALED;
        slot[4] = REG_BLUE_SCALED;
        cfg_write <= 1'b1;
        for (k = 0; k < 5; k++)
        begin
            cfg_index <= slot[k];
            cfg_data <= word[k];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cur_src_alpha = src_alpha;
        cur_inv_alpha = inv_alpha;
        cur_scaled[0] = red;
        cur_scaled[1] = green;
        cur_scaled[2] = blue;
    endtask

    // Tests the reset values of the registers and the edges of both tables. This
    // covers decode writes whose upper index bits must be dropped, encode writes
    // whose upper value bits must be dropped, and an unused opcode beat.
    task automatic test_table_edges();
        offer_beat(OPC_DEC_WRITE, 32'h0, 12'hF00, 16'h0000);
        offer_beat(OPC_DEC_WRITE, 32'hFFFFFFFF, 12'h0FF, 16'hFFFF);
        offer_beat(OPC_DEC_WRITE, 32'h0, 12'hA80, 16'h8000);
        offer_beat(OPC_ENC_WRITE, 32'h0, 12'h000, 16'hFF00);
        offer_beat(OPC_ENC_WRITE, 32'h0, 12'hFFF, 16'hA5FF);
        offer_beat(OPC_ENC_WRITE, 32'h0, 12'h800, 16'h5A7E);
        blend_with_tables(32'h00000000);
        blend_with_tables(32'hFFFFFFFF);
        blend_with_tables(32'hFF80FF00);
        offer_beat(OPC_UNUSED, 32'hFFFFFFFF, 12'hFFF, 16'hFFFF);
        blend_with_tables(32'h12345678);
        drain_results();
    endtask

    // Tests extreme register settings. The first setting drives the alpha sum and
    // the channel quotient past their clamps, using a scaled term above its nominal
    // range. The second sets zero weight, the third sets the top in-range scaled
    // term, and the last is a midpoint.
    task automatic test_setting_extremes();
        int k;
        for (k = 0; k < 4; k++)
        begin
            case (k)
                0: apply_settings(8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                1: apply_settings(8'd0, 8'd0, 24'd0, 24'd0, 24'd0);
                2: apply_settings(8'd255, 8'd0, SCALED_TOP, SCALED_TOP, SCALED_TOP);
                default: apply_settings(8'd128, 8'd127, 24'd1, 24'h800000, 24'h7FFFFF);
            endcase
            blend_with_tables(32'h00000000);
            blend_with_tables(32'hFFFFFFFF);
            blend_with_tables(32'h7F80FF01);
            drain_results();
        end
    endtask

    // Tests back-pressure. The receiver holds off for a long stretch while the
    // sender keeps offering beats, so the output queue fills and the block raises
    // full. The sender then pauses until every expected pixel has come back.
    task automatic test_backpressure();
        int k;
        tx_steady = 1'b1;
        rx_hold_left = 300;
        for (k = 0; k < 40; k++)
            blend_with_tables($urandom);
        drain_results();
        tx_steady = 1'b0;
    endtask

    // Tests random traffic in phases, each with fresh settings and a fixed budget
    // of input beats, table loads included. Most random picks are blends; the rest rewrite
    // table entries or carry the unused opcode. In every fourth phase, both sides
    // run with no idling at all.
    task automatic test_random_traffic();
        int unsigned         phase;
        int unsigned         start_count;
        int unsigned         roll;
        int unsigned         src_pick;
        int unsigned         inv_pick;
        logic [SCALED_W-1:0] scaled_pick [NUM_CH];
        logic [PIXEL_W-1:0]  pix;
        logic [31:0]         noise;
        int                  ch;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            src_pick = $urandom_range(0, 255);
            inv_pick = ($urandom_range(0, 1) == 1) ? 255 - src_pick : $urandom_range(0, 255);
            for (ch = 0; ch < NUM_CH; ch++)
            begin
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    scaled_pick[ch] = 24'hFFFFFF;
                else if (roll == 1)
                    scaled_pick[ch] = 24'd0;
                else
                    scaled_pick[ch] = SCALED_W'($urandom_range(0, SCALED_TOP));
            end
            apply_settings(CH_W'(src_pick), CH_W'(inv_pick),
                           scaled_pick[0], scaled_pick[1], scaled_pick[2]);
            tx_steady = (phase % 4 == 0);
            rx_steady = (phase % 4 == 0);
            start_count = beat_count;
            while (beat_count - start_count < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                noise = $urandom;
                pix = $urandom;
                if (roll < 72)
                begin
                    // Now and then, pin some bytes to their extremes.
                    for (ch = 0; ch < 4; ch++)
                        if ($urandom_range(0, 9) == 0)
                            pix[8*ch +: 8] = noise[ch] ? 8'hFF : 8'h00;
                    blend_with_tables(pix);
                end
                else if (roll < 84)
                    offer_beat(OPC_DEC_WRITE, pix, noise[11:0], noise[31:16]);
                else if (roll < 94)
                    offer_beat(OPC_ENC_WRITE, pix, noise[11:0], noise[31:16]);
                else
                    offer_beat(OPC_UNUSED, pix, noise[11:0], noise[31:16]);
            end
            drain_results();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: checks each beat it pops, then chooses pop for the next edge. A
    // requested hold-off comes first. Otherwise pop runs in random stretches of
    // popping and stalling, or stays high throughout a steady phase.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_pixels.size() == 0)
                log_fault($sformatf("result %08h with nothing expected", blended_pixel));
            else
            begin
                want_pixel = pending_pixels.pop_front();
                if (blended_pixel !== want_pixel)
                    log_fault($sformatf("blended_pixel expected %08h, got %08h",
                                        want_pixel, blended_pixel));
            end
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            pop <= 1'b0;
        end
        else if (rx_steady)
            pop <= 1'b1;
        else
        begin
            if (rx_phase_left == 0)
            begin
                rx_popping = !rx_popping;
                rx_phase_left = rx_popping ? $urandom_range(1, 24) : $urandom_range(1, 6);
            end
            rx_phase_left--;
            pop <= rx_popping;
        end
    end

    // Watchdog: ends the run as a failure if the run goes on far longer than it
    // ever should.
    initial
    begin
        int unsigned cycles_seen;
        cycles_seen = 0;
        while (cycles_seen < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_seen++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_edges();
        test_setting_extremes();
        test_backpressure();
        test_random_traffic();
        drain_results();
        if (pending_pixels.size() != 0)
            log_fault($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
